// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge outside reset.
`define ASSERT_CLKRST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every rising edge, reset included.
`define ASSERT_CLK(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== sv/lbie_pkg.sv =====
// Package with beat types, register map and defaults of the blue LSB embed/extract block.
package lbie_pkg;

  localparam int LengthBitsDefault = 32;
  localparam int AddrWidth         = 4;
  localparam int DataWidth         = 32;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PARITY_SELECT  = 2'd0;
  localparam logic [1:0] REG_EXTRACT_MODE   = 2'd1;
  localparam logic [1:0] REG_MESSAGE_LENGTH = 2'd2;

  typedef struct packed {
    logic       first_pixel;
    logic [7:0] blue_sample;
    logic [7:0] message_byte;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  blue_out;
    logic        byte_taken;
    logic [7:0]  extracted_byte;
    logic        byte_valid;
    logic [31:0] length_out;
    logic        length_valid;
    logic        done_res;
  } result_t;

endpackage

// ===== sv/lsb_blue_interleaved_embed_extract.sv =====
// Top level of the interleaved blue-channel LSB embed/extract block.
//
// Pixels enter on the sample channel (sample_valid, sample_stall, sample_beat)
// in raster order; first_pixel restarts the pixel index and all counters.
// Every second pixel is a carrier. In embed mode the carriers get the header
// (message length, MSB first) and then the message bytes; byte_taken marks the
// beat whose message_byte was consumed. In extract mode the header and bytes
// are read back from the carrier LSBs and blue_out equals the input.
// Each pixel yields one beat on the result channel (result_valid,
// result_stall, result_beat).
// A pixel passes through the input register and then the result register.
// One pixel is taken per cycle while the receiver does not stall; the per-pixel
// update of the counters and shift register is the only loop.
// When the receiver stalls, the result holds and the input register fills;
// sample_stall rises only once both are occupied. Reset clears the registers,
// the counters and both pipeline stages. Configuration over the APB port must
// be written only while the stream is idle; the block does not enforce this.
module lsb_blue_interleaved_embed_extract
  import lbie_pkg::*;
#(
  parameter int LENGTH_BITS = LengthBitsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  pixel_t               sample_beat,
  output logic                 result_valid,
  input  logic                 result_stall,
  output result_t              result_beat,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrWidth-1:0] paddr,
  input  logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0] prdata,
  output logic                 pready
);

  localparam int CW = $clog2(LENGTH_BITS);
  localparam logic [CW-1:0] HeaderLast = CW'(LENGTH_BITS - 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_DATA   = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Configuration registers.
  logic        parity_select;
  logic        extract_mode;
  logic [31:0] message_length;

  // Pipeline registers.
  logic    s1_valid;
  pixel_t  s1_beat;
  logic    load;

  // Stream state.
  logic          index_parity;
  phase_t        phase;
  logic [CW-1:0] header_bit_count;
  logic [2:0]    bit_in_byte;
  logic [7:0]    byte_shift;
  logic [31:0]   bytes_done;
  logic [31:0]   recovered_length;

  logic          index_parity_next;
  phase_t        phase_next;
  logic [CW-1:0] header_bit_count_next;
  logic [2:0]    bit_in_byte_next;
  logic [7:0]    byte_shift_next;
  logic [31:0]   bytes_done_next;
  logic [31:0]   recovered_length_next;

  logic          cur_parity;
  phase_t        cur_phase;
  logic [CW-1:0] cur_hcount;
  logic [2:0]    cur_bit;
  logic [7:0]    cur_shift;
  logic [31:0]   cur_bytes;
  logic [31:0]   cur_length;

  logic [LENGTH_BITS-1:0] header_word;
  logic [31:0]            trunc_length;
  logic [31:0]            target;
  logic [7:0]             src_byte;
  logic                   lsb;
  result_t                res;

  logic cfg_write;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[3:2])
      REG_PARITY_SELECT:  prdata = {31'd0, parity_select};
      REG_EXTRACT_MODE:   prdata = {31'd0, extract_mode};
      REG_MESSAGE_LENGTH: prdata = message_length;
      default:            prdata = '0;
    endcase
  end

  // Handshake: the input register moves on whenever the result register is free.
  assign load         = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !load;

  // Header contents: message_length cut or zero-extended to the header width.
  assign header_word  = LENGTH_BITS'(message_length);
  assign trunc_length = 32'(header_word);
  assign lsb          = s1_beat.blue_sample[0];

  always_comb begin
    // A frame start clears the stream state before this pixel is processed.
    if (s1_beat.first_pixel) begin
      cur_parity = 1'b0;
      cur_phase  = PH_HEADER;
      cur_hcount = '0;
      cur_bit    = '0;
      cur_shift  = '0;
      cur_bytes  = '0;
      cur_length = '0;
    end else begin
      cur_parity = index_parity;
      cur_phase  = phase;
      cur_hcount = header_bit_count;
      cur_bit    = bit_in_byte;
      cur_shift  = byte_shift;
      cur_bytes  = bytes_done;
      cur_length = recovered_length;
    end

    index_parity_next     = ~cur_parity;
    phase_next            = cur_phase;
    header_bit_count_next = cur_hcount;
    bit_in_byte_next      = cur_bit;
    byte_shift_next       = cur_shift;
    bytes_done_next       = cur_bytes;
    recovered_length_next = cur_length;
    target                = trunc_length;
    src_byte              = cur_shift;

    res                = '0;
    res.blue_out       = s1_beat.blue_sample;

    if (cur_parity == parity_select) begin
      case (cur_phase)
        PH_HEADER: begin
          if (extract_mode) begin
            recovered_length_next = {cur_length[30:0], lsb};
          end else begin
            res.blue_out = {s1_beat.blue_sample[7:1], header_word[HeaderLast - cur_hcount]};
          end
          if (cur_hcount >= HeaderLast) begin
            header_bit_count_next = '0;
            if (extract_mode) begin
              res.length_valid = 1'b1;
              target           = recovered_length_next;
            end
            phase_next = (target == 32'd0) ? PH_DONE : PH_DATA;
          end else begin
            header_bit_count_next = cur_hcount + CW'(1);
          end
        end
        PH_DATA: begin
          if (extract_mode) begin
            target          = cur_length;
            byte_shift_next = {cur_shift[6:0], lsb};
          end else begin
            // The first carrier of each byte loads the next message byte.
            if (cur_bit == 3'd0) begin
              src_byte       = s1_beat.message_byte;
              res.byte_taken = 1'b1;
            end
            res.blue_out    = {s1_beat.blue_sample[7:1], src_byte[7]};
            byte_shift_next = {src_byte[6:0], 1'b0};
          end
          if (cur_bit == 3'd7) begin
            bit_in_byte_next = '0;
            if (extract_mode) begin
              res.extracted_byte = byte_shift_next;
              res.byte_valid     = 1'b1;
            end
            bytes_done_next = cur_bytes + 32'd1;
            if (bytes_done_next >= target) begin
              phase_next = PH_DONE;
            end
          end else begin
            bit_in_byte_next = cur_bit + 3'd1;
          end
        end
        default: begin
        end
      endcase
    end

    res.length_out = recovered_length_next;
    res.done_res   = (phase_next != PH_HEADER) && (phase_next != PH_DATA);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_select    <= 1'b0;
      extract_mode     <= 1'b0;
      message_length   <= '0;
      s1_valid         <= 1'b0;
      result_valid     <= 1'b0;
      index_parity     <= 1'b0;
      phase            <= PH_HEADER;
      header_bit_count <= '0;
      bit_in_byte      <= '0;
      byte_shift       <= '0;
      bytes_done       <= '0;
      recovered_length <= '0;
    end else begin
      if (cfg_write) begin
        case (paddr[3:2])
          REG_PARITY_SELECT:  parity_select  <= pwdata[0];
          REG_EXTRACT_MODE:   extract_mode   <= pwdata[0];
          REG_MESSAGE_LENGTH: message_length <= pwdata;
          default: begin
          end
        endcase
      end

      if (sample_valid && !sample_stall) begin
        s1_valid <= 1'b1;
      end else if (load) begin
        s1_valid <= 1'b0;
      end

      if (load) begin
        result_valid     <= 1'b1;
        index_parity     <= index_parity_next;
        phase            <= phase_next;
        header_bit_count <= header_bit_count_next;
        bit_in_byte      <= bit_in_byte_next;
        byte_shift       <= byte_shift_next;
        bytes_done       <= bytes_done_next;
        recovered_length <= recovered_length_next;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_beat <= sample_beat;
    end
    if (load) begin
      result_beat <= res;
    end
  end

endmodule

// ===== sv/lbie_checker.sv =====
// Port-level checker for the blue LSB embed/extract block, with its bind.
`include "assert_macros.svh"

module lbie_checker
  import lbie_pkg::*;
(
  input logic    clk,
  input logic    rst,
  input logic    sample_valid,
  input logic    sample_stall,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result_beat
);

  // Nothing comes out in the cycle after reset.
  `ASSERT_CLK(a_reset_empty, clk, rst |=> !result_valid)

  // A stalled result beat holds.
  `ASSERT_CLKRST(a_result_hold, clk, rst, result_valid && result_stall |=> result_valid && $stable(result_beat))

  // Embedding and extraction never report on the same beat.
  `ASSERT_CLKRST(a_taken_vs_valid, clk, rst, result_valid |-> !(result_beat.byte_taken && result_beat.byte_valid))

  // The header and a data byte cannot complete on the same pixel.
  `ASSERT_CLKRST(a_header_vs_byte, clk, rst, result_valid |-> !(result_beat.length_valid && result_beat.byte_valid))

  // With the result side free, an input-side stall ends unless the result side stalls again.
  `ASSERT_CLKRST(a_no_stuck_stall, clk, rst, sample_stall && !result_stall |=> !sample_stall || result_stall)

endmodule

bind lsb_blue_interleaved_embed_extract lbie_checker u_lbie_checker (.*);

// ===== sim/lsb_blue_interleaved_embed_extract_test.sv =====
// Self-checking testbench for the interleaved blue-channel LSB embed/extract block.
module lsb_blue_interleaved_embed_extract_test;
  import lbie_pkg::*;

  localparam int HeaderBits = LengthBitsDefault;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_DATA   = 2'd1,
    PHASE_DONE   = 2'd2
  } msg_phase_t;

  typedef enum int {
    STALL_NONE,
    STALL_HALF,
    STALL_QUARTER,
    STALL_MOSTLY,
    STALL_HOLD
  } stall_mode_t;

  typedef struct {
    bit          reconfigure;
    bit          parity;
    bit          extract;
    logic [31:0] length;
    pixel_t      px;
    bit          typed;
    result_t     want;
  } directed_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 sample_valid = 1'b0;
  logic                 sample_stall;
  pixel_t               sample_beat = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  result_t              result_beat;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [AddrWidth-1:0] paddr = '0;
  logic [DataWidth-1:0] pwdata = '0;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  lsb_blue_interleaved_embed_extract dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample_beat  (sample_beat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_beat  (result_beat),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // Register copies and per-frame state of the predictor.
  logic        cfg_parity = 1'b0;
  logic        cfg_extract = 1'b0;
  logic [31:0] cfg_length = '0;
  logic        carrier_slot;
  msg_phase_t  msg_phase;
  logic [5:0]  header_count;
  logic [2:0]  bit_pos;
  logic [7:0]  shift_reg;
  logic [31:0] byte_count;
  logic [31:0] header_value;

  result_t         expected_results[$];
  directed_row_t   directed_rows[$];
  int unsigned     mismatch_count = 0;
  int unsigned     results_checked = 0;
  int unsigned     items_sent = 0;
  int unsigned     burst_left = 0;
  bit              offering = 1'b0;

  function automatic void clear_frame();
    carrier_slot = 1'b0;
    msg_phase    = PHASE_HEADER;
    header_count = '0;
    bit_pos      = '0;
    shift_reg    = '0;
    byte_count   = '0;
    header_value = '0;
  endfunction

  function automatic result_t predict_pixel(input pixel_t px);
    result_t     res;
    logic [31:0] target;
    int          pos;
    logic        lsb;
    res = '0;
    if (px.first_pixel) clear_frame();
    res.blue_out = px.blue_sample;
    lsb = px.blue_sample[0];
    if (carrier_slot == cfg_parity && msg_phase != PHASE_DONE) begin
      // Shifting by the full width gives zero, so a 32-bit header keeps all bits.
      target = cfg_length & ((32'd1 << HeaderBits) - 32'd1);
      if (msg_phase == PHASE_HEADER) begin
        if (cfg_extract) begin
          header_value = {header_value[30:0], lsb};
        end else begin
          pos = HeaderBits - 1 - int'(header_count);
          res.blue_out[0] = (pos >= 0 && pos < 32) ? cfg_length[pos] : 1'b0;
        end
        if (int'(header_count) >= HeaderBits - 1) begin
          header_count = '0;
          if (cfg_extract) begin
            res.length_valid = 1'b1;
            target = header_value;
          end
          msg_phase = (target == 0) ? PHASE_DONE : PHASE_DATA;
        end else begin
          header_count = header_count + 6'd1;
        end
      end else begin
        if (cfg_extract) begin
          target = header_value;
          shift_reg = {shift_reg[6:0], lsb};
        end else begin
          if (bit_pos == 3'd0) begin
            shift_reg = px.message_byte;
            res.byte_taken = 1'b1;
          end
          res.blue_out[0] = shift_reg[7];
          shift_reg = {shift_reg[6:0], 1'b0};
        end
        if (bit_pos == 3'd7) begin
          bit_pos = '0;
          if (cfg_extract) begin
            res.extracted_byte = shift_reg;
            res.byte_valid = 1'b1;
          end
          byte_count = byte_count + 32'd1;
          if (byte_count >= target) msg_phase = PHASE_DONE;
        end else begin
          bit_pos = bit_pos + 3'd1;
        end
      end
    end
    carrier_slot = ~carrier_slot;
    res.length_out = header_value;
    res.done_res = (msg_phase == PHASE_DONE);
    return res;
  endfunction

  function automatic void add_row(input bit reconf, input bit par, input bit mode,
                                  input logic [31:0] len, input bit first,
                                  input logic [7:0] blue, input logic [7:0] msg,
                                  input bit typed, input logic [7:0] want_blue,
                                  input logic [31:0] want_len);
    directed_row_t row;
    row.reconfigure = reconf;
    row.parity = par;
    row.extract = mode;
    row.length = len;
    row.px.first_pixel = first;
    row.px.blue_sample = blue;
    row.px.message_byte = msg;
    row.typed = typed;
    row.want = '0;
    row.want.blue_out = want_blue;
    row.want.length_out = want_len;
    directed_rows.push_back(row);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result beat %0h expected none, got one", $time, result_beat);
      end else begin
        want = expected_results.pop_front();
        results_checked++;
        check_field("blue_out", 32'(want.blue_out), 32'(result_beat.blue_out));
        check_field("byte_taken", 32'(want.byte_taken), 32'(result_beat.byte_taken));
        check_field("extracted_byte", 32'(want.extracted_byte),
                    32'(result_beat.extracted_byte));
        check_field("byte_valid", 32'(want.byte_valid), 32'(result_beat.byte_valid));
        check_field("length_out", want.length_out, result_beat.length_out);
        check_field("length_valid", 32'(want.length_valid),
                    32'(result_beat.length_valid));
        check_field("done_res", 32'(want.done_res), 32'(result_beat.done_res));
      end
    end
  end

  // The receiver alternates stall patterns; once, well into the run, it holds
  // off long enough for the block to fill up and stall the sender.
  initial begin : receiver
    stall_mode_t stall_mode;
    int unsigned run;
    bit          long_hold_done;
    long_hold_done = 1'b0;
    forever begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      run = $urandom_range(8, 60);
      if (!long_hold_done && results_checked >= 300) begin
        stall_mode = STALL_HOLD;
        run = 300;
        long_hold_done = 1'b1;
      end
      repeat (run) begin
        @(negedge clk);
        case (stall_mode)
          STALL_NONE:    result_stall <= 1'b0;
          STALL_HALF:    result_stall <= 1'($urandom_range(0, 1));
          STALL_QUARTER: result_stall <= ($urandom_range(0, 3) == 0);
          STALL_MOSTLY:  result_stall <= ($urandom_range(0, 3) != 0);
          default:       result_stall <= 1'b1;
        endcase
      end
    end
  end

  // Called at a falling edge; returns at a falling edge.
  task automatic send_pixel(input pixel_t px, input bit typed, input result_t want);
    result_t predicted;
    sample_beat <= px;
    sample_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (sample_stall);
    predicted = predict_pixel(px);
    expected_results.push_back(typed ? want : predicted);
    items_sent++;
    @(negedge clk);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      sample_valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
    end
  endtask

  task automatic wait_idle();
    if (offering) begin
      sample_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_PARITY_SELECT:  cfg_parity = value[0];
      REG_EXTRACT_MODE:   cfg_extract = value[0];
      REG_MESSAGE_LENGTH: cfg_length = value;
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input bit par, input bit mode, input logic [31:0] len);
    wait_idle();
    write_reg(REG_PARITY_SELECT, {31'd0, par});
    write_reg(REG_EXTRACT_MODE, {31'd0, mode});
    write_reg(REG_MESSAGE_LENGTH, len);
  endtask

  // Sends one frame. Unless the frame is noise, the carrier LSBs spell a header
  // with the given field followed by random bytes, so extraction gets far.
  task automatic send_frame(input bit fresh, input bit noisy,
                            input logic [31:0] header_field, input int unsigned n_pixels);
    pixel_t      px;
    int unsigned carrier_idx;
    int unsigned data_bit;
    logic [7:0]  data_byte;
    int          pos;
    carrier_idx = 0;
    data_byte = '0;
    for (int unsigned i = 0; i < n_pixels; i++) begin
      px.first_pixel = (i == 0) ? fresh : (noisy && $urandom_range(0, 47) == 0);
      px.blue_sample = 8'($urandom_range(0, 255));
      px.message_byte = 8'($urandom_range(0, 255));
      if (!noisy && (i % 2) == cfg_parity) begin
        if (carrier_idx < HeaderBits) begin
          pos = HeaderBits - 1 - int'(carrier_idx);
          px.blue_sample[0] = (pos < 32) ? header_field[pos] : 1'b0;
        end else begin
          data_bit = (carrier_idx - HeaderBits) % 8;
          if (data_bit == 0) data_byte = 8'($urandom_range(0, 255));
          px.blue_sample[0] = data_byte[7 - data_bit];
        end
        carrier_idx++;
      end
      send_pixel(px, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    logic [31:0] header_field;
    int unsigned n_bytes;
    int unsigned n_pixels;
    bit          fresh;
    bit          noisy;
    bit          mode;
    clear_frame();

    // Reset state, the extremes of the length, both parities, both modes,
    // a mode and length change mid-frame, and a restart mid-frame.
    add_row(0, 0, 0, 32'h0, 1, 8'hFF, 8'hAA, 1, 8'hFE, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'hFF, 8'h55, 1, 8'hFF, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'h01, 8'h00, 1, 8'h00, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'h00, 8'hFF, 1, 8'h00, 32'h0);
    add_row(1, 1, 0, 32'hFFFF_FFFF, 1, 8'h00, 8'hFF, 1, 8'h00, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 1, 8'h01, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'hFE, 8'h00, 1, 8'hFE, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'hFE, 8'hFF, 1, 8'hFF, 32'h0);
    add_row(1, 0, 1, 32'h0, 1, 8'hFF, 8'h00, 1, 8'hFF, 32'h1);
    add_row(0, 0, 0, 32'h0, 0, 8'h80, 8'h00, 1, 8'h80, 32'h1);
    add_row(0, 0, 0, 32'h0, 0, 8'h01, 8'h00, 1, 8'h01, 32'h3);
    add_row(0, 0, 0, 32'h0, 0, 8'h00, 8'h00, 1, 8'h00, 32'h3);
    add_row(0, 0, 0, 32'h0, 0, 8'h00, 8'hC3, 0, 8'h00, 32'h0);
    add_row(1, 1, 0, 32'h1, 0, 8'hAA, 8'h5A, 0, 8'h00, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'h55, 8'hA5, 0, 8'h00, 32'h0);
    add_row(0, 0, 0, 32'h0, 0, 8'hFF, 8'hFF, 0, 8'h00, 32'h0);
    add_row(0, 0, 0, 32'h0, 1, 8'h00, 8'h00, 0, 8'h00, 32'h0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].reconfigure)
        configure(directed_rows[r].parity, directed_rows[r].extract, directed_rows[r].length);
      send_pixel(directed_rows[r].px, directed_rows[r].typed, directed_rows[r].want);
    end

    // Mostly well-formed frames with short messages; some frames are noise,
    // cut short, or continue the previous frame under new settings.
    while (items_sent < 1100) begin
      n_bytes = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(0, 4);
      case ($urandom_range(0, 7))
        0:       header_field = 32'hFFFF_FFFF;
        1:       header_field = $urandom;
        default: header_field = n_bytes;
      endcase
      noisy = ($urandom_range(0, 5) == 0);
      fresh = ($urandom_range(0, 7) != 0);
      mode = 1'($urandom_range(0, 1));
      if (!fresh || $urandom_range(0, 3) != 0)
        configure(1'($urandom_range(0, 1)), mode, mode ? $urandom : header_field);
      n_pixels = 2 * (HeaderBits + 8 * n_bytes) + $urandom_range(0, 5);
      if ($urandom_range(0, 5) == 0) n_pixels = $urandom_range(1, n_pixels);
      if (n_pixels > 1100 - items_sent) n_pixels = 1100 - items_sent;
      send_frame(fresh, noisy, header_field, n_pixels);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/lbie_pkg.sv
sv/lsb_blue_interleaved_embed_extract.sv
sv/lbie_checker.sv
sim/lsb_blue_interleaved_embed_extract_test.sv
